@@ sv/sws_pkg.sv @@
// Shared definitions for the sliding window statistics block.
// Holds operation codes, value limits and the request/response layouts.
// No dependencies.
package sws_pkg;

   localparam int VALUE_W     = 24;
   localparam int LANE_W      = 4;
   localparam int SUM_W       = 30;
   localparam int SUMSQ_W     = 52;
   localparam int COUNT_W     = 7;
   localparam int ACC_W       = 64;
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 144;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 24'sh7FFFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 24'sh800000;

   localparam logic signed [ACC_W-1:0] SUM_HI   = 64'sd536870911;
   localparam logic signed [ACC_W-1:0] SUM_LO   = -64'sd536870912;
   localparam logic signed [ACC_W-1:0] SUMSQ_HI = 64'sh000F_FFFF_FFFF_FFFF;

   // Response payload, first field in the highest bits.
   typedef struct packed {
      logic [2:0]                pad;
      logic [SUMSQ_W-1:0]        window_sum_sq;
      logic [SUM_W-1:0]          window_sum;
      logic signed [VALUE_W-1:0] window_max;
      logic signed [VALUE_W-1:0] window_min;
      logic [COUNT_W-1:0]        valid_count;
      logic [LANE_W-1:0]         result_lane;
   } rsp_type;

endpackage

@@ sv/sliding_window_statistics.sv @@
// Sliding window min/max/sum/sum-of-squares over per-lane sample rings.
// Depends on sws_pkg for codes, limits and the response layout.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata: lane, sample_value; tuser: op, valid
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: lane, count, min, max, sum, sum_sq
//  csr     | in  | csr_valid/csr_ready    | csr_data: force_valid
//
// An insert request passes ST_LANE, ST_OLD, ST_SQ_NEW, ST_SQ_OLD, ST_ACC and ST_WRITE
// before a valid response, with a rescan (ST_SCAN, ST_DRAIN) before ST_WRITE when the
// oldest entry was the current minimum or maximum: the rescan reads the lane ring one
// entry per cycle through the single ring read port. A clear or an out-of-range lane
// responds in the cycle after acceptance. One request is in flight at a time; the
// block takes the next request once the response has been taken. Reset is synchronous
// and marks every lane empty through per-lane valid bits, so no clearing pass is needed.
module sliding_window_statistics #(
   parameter int WINDOW_DEPTH = 64,
   parameter int NUM_LANES    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata, low bit up: lane[3:0], sample_value[27:4], zero pad[31:28]
   input  logic [sws_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser, low bit up: operation[0], sample_valid[1]
   input  logic [sws_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata, low bit up: result_lane[3:0], valid_count[10:4], window_min[34:11],
   // window_max[58:35], window_sum[88:59], window_sum_sq[140:89], zero pad[143:141]
   output logic [sws_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_data
);
   import sws_pkg::*;

   localparam int POS_W      = $clog2(WINDOW_DEPTH);
   localparam int CNT_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int LANE_AW    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
   localparam int RING_DEPTH = NUM_LANES * WINDOW_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // Per-lane bookkeeping as held in the lane memory.
   typedef struct packed {
      logic [POS_W-1:0]          head;
      logic [CNT_W-1:0]          fill;
      logic [CNT_W-1:0]          count;
      logic signed [VALUE_W-1:0] min_val;
      logic signed [VALUE_W-1:0] max_val;
      logic [ACC_W-1:0]          sum;
      logic [ACC_W-1:0]          sum_sq;
   } lane_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LANE,
      ST_OLD,
      ST_SQ_NEW,
      ST_SQ_OLD,
      ST_ACC,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Request fields.
   op_type                    req_op;
   logic                      req_sample_valid;
   logic [LANE_W-1:0]         req_lane;
   logic signed [VALUE_W-1:0] req_sample;

   assign req_op           = op_type'(req_tuser[0]);
   assign req_sample_valid = req_tuser[1];
   assign req_lane         = req_tdata[LANE_W-1:0];
   assign req_sample       = req_tdata[LANE_W+VALUE_W-1:LANE_W];

   state_type                 state_ff;
   logic                      force_valid_ff;
   logic [NUM_LANES-1:0]      lane_valid_ff;
   logic [LANE_AW-1:0]        lane_idx_ff;
   logic [LANE_W-1:0]         lane_echo_ff;
   logic signed [VALUE_W-1:0] sample_ff;
   logic                      nv_ff;
   lane_type                  work_ff;
   logic [RING_AW-1:0]        base_ff;
   logic                      full_ff;
   logic signed [VALUE_W-1:0] ov_ff;
   logic                      ostored_ff;
   logic                      ovalid_ff;
   logic                      min_scan_ff;
   logic                      max_scan_ff;
   logic signed [VALUE_W-1:0] scan_min_ff;
   logic signed [VALUE_W-1:0] scan_max_ff;
   logic [POS_W-1:0]          scan_pos_ff;
   logic [POS_W-1:0]          scan_left_ff;
   logic                      scan_pend_ff;
   logic signed [47:0]        prod_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   // Memories and their registered read data.
   lane_type                  lane_mem [NUM_LANES];
   lane_type                  lane_rd_ff;
   entry_type                 ring_mem [RING_DEPTH];
   entry_type                 ring_rd_ff;

   logic [LANE_AW-1:0]        lane_raddr;
   logic [RING_AW-1:0]        ring_raddr;
   logic [RING_AW-1:0]        ring_waddr;
   lane_type                  lane_reset;
   lane_type                  lane_cur;
   lane_type                  lane_wr;
   logic                      lane_we;
   logic                      ring_we;
   entry_type                 ring_wdata;
   logic signed [VALUE_W-1:0] mul_op;
   logic signed [VALUE_W-1:0] ov_in;
   logic                      ostored_in;
   logic                      min_beat;
   logic                      max_beat;
   logic                      scan_hit;
   logic [CNT_W-1:0]          count_in;
   logic                      lane_in_range;

   function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
      return (p == POS_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] s);
      if (s > SUM_HI) begin
         return {1'b0, {(SUM_W-1){1'b1}}};
      end else if (s < SUM_LO) begin
         return {1'b1, {(SUM_W-1){1'b0}}};
      end
      return s[SUM_W-1:0];
   endfunction

   function automatic logic [SUMSQ_W-1:0] sat_sq(input logic signed [ACC_W-1:0] s);
      if (s[ACC_W-1]) begin
         return '0;
      end else if (s > SUMSQ_HI) begin
         return '1;
      end
      return s[SUMSQ_W-1:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [LANE_W-1:0] lane, input lane_type st);
      rsp_type r;
      r.pad           = '0;
      r.result_lane   = lane;
      r.valid_count   = (32'(st.count) > 127) ? 7'd127 : COUNT_W'(st.count);
      r.window_min    = st.min_val;
      r.window_max    = st.max_val;
      r.window_sum    = sat_sum($signed(st.sum));
      r.window_sum_sq = sat_sq($signed(st.sum_sq));
      return r;
   endfunction

   always_comb begin
      lane_reset         = '0;
      lane_reset.min_val = VAL_MAX;
      lane_reset.max_val = VAL_MIN;
   end

   assign lane_in_range = (32'(req_lane) < NUM_LANES);
   assign lane_raddr    = LANE_AW'(req_lane);
   // A lane whose valid bit is clear reads as freshly reset.
   assign lane_cur      = lane_valid_ff[lane_idx_ff] ? lane_rd_ff : lane_reset;

   always_comb begin
      case (state_ff)
         ST_LANE: ring_raddr = base_ff + RING_AW'(lane_cur.head);
         ST_SCAN: ring_raddr = base_ff + RING_AW'(scan_pos_ff);
         default: ring_raddr = base_ff;
      endcase
   end

   // Oldest entry only matters once the ring has wrapped.
   assign ov_in      = full_ff ? ring_rd_ff.value : '0;
   assign ostored_in = full_ff && ring_rd_ff.valid;
   assign min_beat   = nv_ff && (sample_ff < work_ff.min_val);
   assign max_beat   = nv_ff && (sample_ff > work_ff.max_val);
   assign scan_hit   = scan_pend_ff && (force_valid_ff || ring_rd_ff.valid);

   // Shared squaring unit operand.
   assign mul_op = (state_ff == ST_SQ_NEW) ? sample_ff : ov_ff;

   always_comb begin
      count_in = work_ff.count;
      if (force_valid_ff) begin
         count_in = full_ff ? CNT_W'(WINDOW_DEPTH) : work_ff.fill + 1'b1;
      end else if (nv_ff && !ostored_ff) begin
         if (work_ff.count < CNT_W'(WINDOW_DEPTH)) begin
            count_in = work_ff.count + 1'b1;
         end
      end else if (!nv_ff && ostored_ff) begin
         if (work_ff.count != '0) begin
            count_in = work_ff.count - 1'b1;
         end
      end
   end

   always_comb begin
      lane_wr      = work_ff;
      lane_wr.head = pos_next(work_ff.head);
      if (!full_ff) begin
         lane_wr.fill = work_ff.fill + 1'b1;
      end
      if (min_scan_ff) begin
         lane_wr.min_val = scan_min_ff;
      end
      if (max_scan_ff) begin
         lane_wr.max_val = scan_max_ff;
      end
   end

   assign lane_we          = (state_ff == ST_WRITE);
   assign ring_we          = (state_ff == ST_WRITE);
   assign ring_waddr       = base_ff + RING_AW'(work_ff.head);
   assign ring_wdata.valid = nv_ff;
   assign ring_wdata.value = sample_ff;

   always_ff @(posedge clock) begin
      if (lane_we) begin
         lane_mem[lane_idx_ff] <= lane_wr;
      end
      lane_rd_ff <= lane_mem[lane_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_op * mul_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         force_valid_ff <= 1'b0;
         lane_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_pend_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            force_valid_ff <= csr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  lane_idx_ff  <= lane_raddr;
                  lane_echo_ff <= req_lane;
                  sample_ff    <= req_sample;
                  nv_ff        <= req_sample_valid || force_valid_ff;
                  base_ff      <= RING_AW'(lane_raddr) * RING_AW'(WINDOW_DEPTH);
                  if (req_op == OP_CLEAR || !lane_in_range) begin
                     if (req_op == OP_CLEAR) begin
                        lane_valid_ff <= '0;
                     end
                     rsp_ff       <= make_rsp(req_lane, lane_reset);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     state_ff <= ST_LANE;
                  end
               end
            end
            ST_LANE: begin
               work_ff  <= lane_cur;
               full_ff  <= (lane_cur.fill >= CNT_W'(WINDOW_DEPTH));
               state_ff <= ST_OLD;
            end
            ST_OLD: begin
               ov_ff       <= ov_in;
               ostored_ff  <= ostored_in;
               ovalid_ff   <= full_ff && (force_valid_ff || ring_rd_ff.valid);
               if (min_beat) begin
                  work_ff.min_val <= sample_ff;
               end
               if (max_beat) begin
                  work_ff.max_val <= sample_ff;
               end
               // The oldest entry was the extreme and the new sample does not replace it.
               min_scan_ff  <= !min_beat && full_ff && (work_ff.min_val == ov_in);
               max_scan_ff  <= !max_beat && full_ff && (work_ff.max_val == ov_in);
               scan_min_ff  <= nv_ff ? sample_ff : VAL_MAX;
               scan_max_ff  <= nv_ff ? sample_ff : VAL_MIN;
               scan_pos_ff  <= pos_next(work_ff.head);
               scan_left_ff <= POS_W'(WINDOW_DEPTH - 1);
               scan_pend_ff <= 1'b0;
               state_ff     <= ST_SQ_NEW;
            end
            ST_SQ_NEW: begin
               if (nv_ff) begin
                  work_ff.sum <= work_ff.sum + ACC_W'(sample_ff);
               end
               state_ff <= ST_SQ_OLD;
            end
            ST_SQ_OLD: begin
               if (ovalid_ff) begin
                  work_ff.sum <= work_ff.sum - ACC_W'(ov_ff);
               end
               if (nv_ff) begin
                  work_ff.sum_sq <= work_ff.sum_sq + ACC_W'(prod_ff);
               end
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (ovalid_ff) begin
                  work_ff.sum_sq <= work_ff.sum_sq - ACC_W'(prod_ff);
               end
               work_ff.count <= count_in;
               state_ff      <= (min_scan_ff || max_scan_ff) ? ST_SCAN : ST_WRITE;
            end
            ST_SCAN: begin
               if (scan_hit && ring_rd_ff.value < scan_min_ff) begin
                  scan_min_ff <= ring_rd_ff.value;
               end
               if (scan_hit && ring_rd_ff.value > scan_max_ff) begin
                  scan_max_ff <= ring_rd_ff.value;
               end
               scan_pos_ff  <= pos_next(scan_pos_ff);
               scan_left_ff <= scan_left_ff - 1'b1;
               scan_pend_ff <= 1'b1;
               if (scan_left_ff == POS_W'(1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (scan_hit && ring_rd_ff.value < scan_min_ff) begin
                  scan_min_ff <= ring_rd_ff.value;
               end
               if (scan_hit && ring_rd_ff.value > scan_max_ff) begin
                  scan_max_ff <= ring_rd_ff.value;
               end
               scan_pend_ff <= 1'b0;
               state_ff     <= ST_WRITE;
            end
            ST_WRITE: begin
               lane_valid_ff[lane_idx_ff] <= 1'b1;
               rsp_ff       <= make_rsp(lane_echo_ff, lane_wr);
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign csr_ready  = 1'b1;

   // Only one request is ever in flight.
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted while a response is pending");

   // A clear empties every lane in the following cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == OP_CLEAR) |=> (lane_valid_ff == '0))
      else $error("lanes still marked valid after a clear");

   // The rescan never runs past the other entries of the ring.
   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_left_ff != '0))
      else $error("rescan ran past the window");

   // The valid count written back stays within the window depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (work_ff.count <= CNT_W'(WINDOW_DEPTH)))
      else $error("valid count exceeds the window depth");

endmodule
